// ----- rtl/clock_set_accelerated_stepper_assert.svh -----
// Assertion macros shared by the clock-set stepper RTL.
`ifndef CLOCK_SET_ACCELERATED_STEPPER_ASSERT_SVH
`define CLOCK_SET_ACCELERATED_STEPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSAS_ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("csas assertion failed");
`define CSAS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("csas assertion failed");
`else
`define CSAS_ASSERT_CLK(label, prop)
`define CSAS_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/csas_pkg.sv -----
`default_nettype none

package csas_pkg;

    localparam logic [8:0] DEGREES_FULL  = 9'd360;
    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [4:0] HOUR_NOON     = 5'd12;
    localparam logic [4:0] HOUR_ELEVEN   = 5'd11;
    localparam logic [7:0] SPEED_MAX     = 8'hFF;

    localparam logic [7:0] SLOW_LIMIT_RST   = 8'h0A;
    localparam logic [7:0] MEDIUM_LIMIT_RST = 8'h1E;
    localparam logic [7:0] FAST_LIMIT_RST   = 8'h3C;

    localparam logic [8:0] MINUTE_HAND_RST  = 9'd0;
    localparam logic [8:0] HOUR_HAND_RST    = 9'd300;
    localparam logic [4:0] HOUR_COUNT_RST   = 5'd10;
    localparam logic [5:0] MINUTE_COUNT_RST = 6'd0;

    localparam logic [1:0] REG_SLOW_LIMIT   = 2'd0;
    localparam logic [1:0] REG_MEDIUM_LIMIT = 2'd1;
    localparam logic [1:0] REG_FAST_LIMIT   = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_BACK = 2'd1,
        DIR_FWD  = 2'd2
    } dir_t;

    typedef struct packed {
        logic [7:0] slow;
        logic [7:0] mid;
        logic [7:0] fast;
    } limits_t;

    typedef struct packed {
        logic       kind;
        logic       confirm_pressed;
        logic       left_held;
        logic       right_held;
        logic [4:0] load_hours;
        logic [5:0] load_minutes;
    } item_t;

    typedef struct packed {
        logic [8:0] minute_hand;
        logic [8:0] hour_hand;
        logic [4:0] hour_count;
        logic [5:0] minute_count;
        logic       afternoon;
        dir_t       direction;
        logic [7:0] hold_speed;
    } clk_state_t;

    function automatic logic [2:0] mod6(input logic [8:0] x);
        logic [18:0] prod;
        logic [8:0]  quot;
        logic [8:0]  rem;
        prod = 19'(x) * 19'd171;
        quot = prod[18:10];
        rem  = x - 9'(quot * 9'd6);
        return rem[2:0];
    endfunction

    function automatic logic [8:0] minute_angle(input logic [5:0] m);
        return 9'(m) * 9'd6;
    endfunction

    function automatic logic [8:0] hour_angle(input logic [4:0] h, input logic [5:0] m);
        logic [4:0]  h12;
        logic [13:0] prod;
        logic [2:0]  tens;
        h12  = (h >= HOUR_NOON) ? h - HOUR_NOON : h;
        prod = 14'(m) * 14'd205;
        tens = prod[13:11];
        return 9'(h12) * 9'd30 + 9'(tens) * 9'd5;
    endfunction

    function automatic logic [2:0] step_size(input logic [7:0] spd, input limits_t lim);
        if (spd > lim.fast) return 3'd6;
        if (spd > lim.mid) return 3'd3;
        if (spd > lim.slow) return 3'd2;
        return 3'd1;
    endfunction

    function automatic logic [8:0] sweep(input logic [8:0] ang, input dir_t dir,
                                         input logic [7:0] spd, input limits_t lim);
        logic [8:0] d;
        logic [8:0] res;
        d   = 9'(step_size(spd, lim));
        res = ang;
        case (dir)
            DIR_BACK:
            begin
                if (ang == 9'd0) res = DEGREES_FULL - d;
                else if (ang >= d) res = ang - d;
                else res = 9'd0;
            end
            DIR_FWD:
            begin
                if (ang < DEGREES_FULL - d) res = ang + d;
                else res = 9'd0;
            end
            default:
            begin
                res = ang;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/csas_step.sv -----
`default_nettype none

module csas_step (
    input  wire csas_pkg::clk_state_t cur,
    input  wire csas_pkg::limits_t    lim,
    input  wire csas_pkg::item_t      item,
    output csas_pkg::clk_state_t      nxt,
    output logic                      req
);

    logic [4:0]      hc_load;
    logic [5:0]      mc_load;
    csas_pkg::dir_t  dir_new;
    logic [7:0]      spd_new;

    always_comb
    begin
        hc_load = (item.load_hours > csas_pkg::HOUR_MAX) ? csas_pkg::HOUR_MAX
                                                          : item.load_hours;
        mc_load = (item.load_minutes > csas_pkg::MINUTE_MAX) ? csas_pkg::MINUTE_MAX
                                                              : item.load_minutes;
        dir_new = item.right_held ? csas_pkg::DIR_FWD
                : (item.left_held ? csas_pkg::DIR_BACK : csas_pkg::DIR_NONE);
        spd_new = (cur.hold_speed < csas_pkg::SPEED_MAX) ? cur.hold_speed + 8'd1
                                                          : cur.hold_speed;
        nxt = cur;
        req = 1'b0;
        if (item.kind)
        begin
            nxt.hour_count   = hc_load;
            nxt.minute_count = mc_load;
            nxt.minute_hand  = csas_pkg::minute_angle(mc_load);
            nxt.hour_hand    = csas_pkg::hour_angle(hc_load, mc_load);
            nxt.afternoon    = (hc_load >= csas_pkg::HOUR_NOON);
        end
        else if (csas_pkg::mod6(cur.minute_hand) != 3'd0)
        begin
            nxt.minute_hand = csas_pkg::sweep(cur.minute_hand, cur.direction,
                                              cur.hold_speed, lim);
        end
        else
        begin
            nxt.minute_hand = csas_pkg::minute_angle(cur.minute_count);
            nxt.hour_hand   = csas_pkg::hour_angle(cur.hour_count, cur.minute_count);
            if (item.confirm_pressed)
            begin
                req = 1'b1;
            end
            else
            begin
                nxt.direction = dir_new;
                case (dir_new)
                    csas_pkg::DIR_FWD:
                    begin
                        nxt.hold_speed  = spd_new;
                        nxt.minute_hand = csas_pkg::sweep(
                            csas_pkg::minute_angle(cur.minute_count), dir_new, spd_new, lim);
                        if (cur.minute_count < csas_pkg::MINUTE_MAX)
                        begin
                            nxt.minute_count = cur.minute_count + 6'd1;
                        end
                        else
                        begin
                            nxt.minute_count = 6'd0;
                            nxt.hour_count = (cur.hour_count < csas_pkg::HOUR_MAX)
                                             ? cur.hour_count + 5'd1 : 5'd0;
                            if (nxt.hour_count == 5'd0) nxt.afternoon = 1'b0;
                            else if (nxt.hour_count == csas_pkg::HOUR_NOON)
                                nxt.afternoon = 1'b1;
                        end
                    end
                    csas_pkg::DIR_BACK:
                    begin
                        nxt.hold_speed  = spd_new;
                        nxt.minute_hand = csas_pkg::sweep(
                            csas_pkg::minute_angle(cur.minute_count), dir_new, spd_new, lim);
                        if (cur.minute_count > 6'd0)
                        begin
                            nxt.minute_count = cur.minute_count - 6'd1;
                        end
                        else
                        begin
                            nxt.minute_count = csas_pkg::MINUTE_MAX;
                            nxt.hour_count = (cur.hour_count > 5'd0)
                                             ? cur.hour_count - 5'd1 : csas_pkg::HOUR_MAX;
                            if (nxt.hour_count == csas_pkg::HOUR_ELEVEN)
                                nxt.afternoon = 1'b0;
                            else if (nxt.hour_count == csas_pkg::HOUR_MAX)
                                nxt.afternoon = 1'b1;
                        end
                    end
                    default:
                    begin
                        nxt.hold_speed = 8'd0;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/clock_set_accelerated_stepper.sv -----
// Clock-set stepper: one item per transfer, one result per item. A frame item
// sweeps the minute hand or, at a six-degree mark, snaps the hands, raises a
// confirm request or steps the minutes in the held direction with a hold
// speed that widens the sweep step past the three APB limit registers. A load
// item sets the time. Items are taken back to back, one per cycle, while the
// result register is not stalled; an item is captured in the item register
// and its result is registered in the result register through the
// combinational step logic. Write the limit registers only while no item is
// in flight.
`default_nettype none

module clock_set_accelerated_stepper (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        psel,
    input  wire        penable,
    input  wire        pwrite,
    input  wire [3:0]  paddr,
    input  wire [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready,
    input  wire        item_valid,
    output logic       item_ready,
    input  wire        kind,
    input  wire        confirm_pressed,
    input  wire        left_held,
    input  wire        right_held,
    input  wire [4:0]  load_hours,
    input  wire [5:0]  load_minutes,
    output logic       result_valid,
    input  wire        result_ready,
    output logic [8:0] minute_angle_out,
    output logic [8:0] hour_angle_out,
    output logic [4:0] hours_out,
    output logic [5:0] minutes_out,
    output logic       is_pm,
    output logic       confirm_request
);

    csas_pkg::limits_t    limits_reg;
    csas_pkg::item_t      item_reg;
    logic                 item_valid_reg;
    csas_pkg::clk_state_t state_reg;
    csas_pkg::clk_state_t state_next;
    logic                 req_next;
    logic                 result_valid_reg;
    logic                 confirm_reg;
    logic                 advance;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign advance   = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.slow <= csas_pkg::SLOW_LIMIT_RST;
            limits_reg.mid  <= csas_pkg::MEDIUM_LIMIT_RST;
            limits_reg.fast <= csas_pkg::FAST_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                csas_pkg::REG_SLOW_LIMIT:   limits_reg.slow <= pwdata[7:0];
                csas_pkg::REG_MEDIUM_LIMIT: limits_reg.mid  <= pwdata[7:0];
                csas_pkg::REG_FAST_LIMIT:   limits_reg.fast <= pwdata[7:0];
                default:                    limits_reg      <= limits_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            csas_pkg::REG_SLOW_LIMIT:   prdata = {24'd0, limits_reg.slow};
            csas_pkg::REG_MEDIUM_LIMIT: prdata = {24'd0, limits_reg.mid};
            csas_pkg::REG_FAST_LIMIT:   prdata = {24'd0, limits_reg.fast};
            default:                    prdata = 32'd0;
        endcase
    end

    // hold the item while the result register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg.kind            <= kind;
            item_reg.confirm_pressed <= confirm_pressed;
            item_reg.left_held       <= left_held;
            item_reg.right_held      <= right_held;
            item_reg.load_hours      <= load_hours;
            item_reg.load_minutes    <= load_minutes;
        end
    end

    csas_step u_step (
        .cur  (state_reg),
        .lim  (limits_reg),
        .item (item_reg),
        .nxt  (state_next),
        .req  (req_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.minute_hand  <= csas_pkg::MINUTE_HAND_RST;
            state_reg.hour_hand    <= csas_pkg::HOUR_HAND_RST;
            state_reg.hour_count   <= csas_pkg::HOUR_COUNT_RST;
            state_reg.minute_count <= csas_pkg::MINUTE_COUNT_RST;
            state_reg.afternoon    <= 1'b0;
            state_reg.direction    <= csas_pkg::DIR_NONE;
            state_reg.hold_speed   <= 8'd0;
            result_valid_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            confirm_reg <= req_next;
        end
    end

    assign result_valid     = result_valid_reg;
    assign minute_angle_out = state_reg.minute_hand;
    assign hour_angle_out   = state_reg.hour_hand;
    assign hours_out        = state_reg.hour_count;
    assign minutes_out      = state_reg.minute_count;
    assign is_pm            = state_reg.afternoon;
    assign confirm_request  = confirm_reg;

`include "clock_set_accelerated_stepper_assert.svh"

    `CSAS_ASSERT_ALWAYS(a_time_range, result_valid |-> (hours_out <= 5'd23 && minutes_out <= 6'd59))
    `CSAS_ASSERT_CLK(a_period_match, result_valid |-> (is_pm == (hours_out >= 5'd12)))
    `CSAS_ASSERT_CLK(a_confirm_snapped, (result_valid && confirm_request) |-> (minute_angle_out == 9'(minutes_out) * 9'd6))
    `CSAS_ASSERT_CLK(a_hour_angle_range, result_valid |-> (hour_angle_out < 9'd360))

endmodule

`default_nettype wire
